/* rtl/cdd_pkg.sv */
// Package for the calendar day difference block: field widths, order codes,
// reciprocal constants for the divide-by-100 steps and the month table.
// No dependencies; every other file in rtl/ uses it by scoped names.
package cdd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int DIST_W  = 21;
  localparam int CODE_W  = 2;

  localparam int unsigned MAX_YEAR_DEF = 4095;

  // floor(x / 100) = (x * RECIP100) >> RECIP_SHIFT, exact for x below 8192
  localparam int RECIP_X_W   = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = 26;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_X_W-1:0] RECIP100 = 13'd5243;

  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
  localparam int DBM_W = 9;

  typedef enum logic [CODE_W-1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LATER   = 2'd1,
    ORD_EARLIER = 2'd2
  } order_t;

  // load strobes for the three day-number stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // days of the months before month m, leap day not counted
  function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

/* rtl/calendar_day_difference.sv */
// Top level of the calendar day difference block: input stage, two
// day-number pipelines (cdd_day_number), difference and output stage.
// Depends on cdd_pkg and cdd_day_number.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  in      | in_valid / in_ready | first_/second_ day, month, year
//  out     | out_valid/out_ready | day_distance, order_code
//
// One date pair enters per cycle while no stall on out_ready holds the pipeline; a
// result passes through the stages in order (clamp/compare, products, year sums,
// day number, abs diff): a five-stage pipeline, each stage holding one beat.
// Reset (rst, synchronous) clears the stage valid bits only.
// A stall on out_ready fills empty stages first; in_ready drops only when
// every stage holds a beat, so nothing is dropped or repeated.
module calendar_day_difference #(
  parameter int unsigned MAX_YEAR = cdd_pkg::MAX_YEAR_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cdd_pkg::DAY_W-1:0]    first_day,
  input  logic [cdd_pkg::MONTH_W-1:0]  first_month,
  input  logic [cdd_pkg::YEAR_W-1:0]   first_year,
  input  logic [cdd_pkg::DAY_W-1:0]    second_day,
  input  logic [cdd_pkg::MONTH_W-1:0]  second_month,
  input  logic [cdd_pkg::YEAR_W-1:0]   second_year,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cdd_pkg::DIST_W-1:0]   day_distance,
  output logic [cdd_pkg::CODE_W-1:0]   order_code
);

  localparam int YW = cdd_pkg::YEAR_W;
  localparam int NW = cdd_pkg::DIST_W;

  // stage valid bits; stage 5 is the output register
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;
  cdd_pkg::stage_en_t en_dn;

  // a stage loads when it is empty or its holder moves on
  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign en_dn    = '{s2: en2, s3: en3, s4: en4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // stage 1: saturate the years, compare fields year, month, day
  logic [YW-1:0] y1_clamp;
  logic [YW-1:0] y2_clamp;
  cdd_pkg::order_t code_next;

  assign y1_clamp = (32'(first_year) > MAX_YEAR) ? YW'(MAX_YEAR) : first_year;
  assign y2_clamp = (32'(second_year) > MAX_YEAR) ? YW'(MAX_YEAR) : second_year;

  always_comb begin
    if (y1_clamp != y2_clamp) begin
      code_next = (y1_clamp > y2_clamp) ? cdd_pkg::ORD_LATER : cdd_pkg::ORD_EARLIER;
    end else if (first_month != second_month) begin
      code_next = (first_month > second_month) ? cdd_pkg::ORD_LATER
                                               : cdd_pkg::ORD_EARLIER;
    end else if (first_day != second_day) begin
      code_next = (first_day > second_day) ? cdd_pkg::ORD_LATER : cdd_pkg::ORD_EARLIER;
    end else begin
      code_next = cdd_pkg::ORD_EQUAL;
    end
  end

  logic [cdd_pkg::DAY_W-1:0]   d1_s1, d2_s1;
  logic [cdd_pkg::MONTH_W-1:0] m1_s1, m2_s1;
  logic [YW-1:0]               y1_s1, y2_s1;
  cdd_pkg::order_t             code1, code2, code3, code4;

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_s1 <= first_day;
      m1_s1 <= first_month;
      y1_s1 <= y1_clamp;
      d2_s1 <= second_day;
      m2_s1 <= second_month;
      y2_s1 <= y2_clamp;
      code1 <= code_next;
    end
    // carry the order code alongside the day-number stages
    if (en2) code2 <= code1;
    if (en3) code3 <= code2;
    if (en4) code4 <= code3;
  end

  // stages 2 to 4: day numbers of both dates
  logic [NW-1:0] num1;
  logic [NW-1:0] num2;

  cdd_day_number u_dn_first (
    .clk     (clk),
    .en      (en_dn),
    .year    (y1_s1),
    .month   (m1_s1),
    .day     (d1_s1),
    .day_num (num1)
  );

  cdd_day_number u_dn_second (
    .clk     (clk),
    .en      (en_dn),
    .year    (y2_s1),
    .month   (m2_s1),
    .day     (d2_s1),
    .day_num (num2)
  );

  // stage 5: absolute difference into the output register
  always_ff @(posedge clk) begin
    if (en5) begin
      day_distance <= (num1 >= num2) ? (num1 - num2) : (num2 - num1);
      order_code   <= code4;
    end
  end

  // equal fields give equal day numbers
  a_equal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (order_code == cdd_pkg::ORD_EQUAL) |-> (day_distance == '0))
    else $error("equal dates with nonzero distance");

  // input stalls only when every stage holds a beat
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && v4 && out_valid))
    else $error("input stalled with an empty stage");

  // an accepted beat lands in stage 1
  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted beat lost at stage 1");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* rtl/cdd_day_number.sv */
// Three-stage day number unit: days from year 0 to the given date.
// Depends on cdd_pkg; instantiated twice by calendar_day_difference.
module cdd_day_number (
  input  logic                         clk,
  input  cdd_pkg::stage_en_t           en,
  input  logic [cdd_pkg::YEAR_W-1:0]   year,
  input  logic [cdd_pkg::MONTH_W-1:0]  month,
  input  logic [cdd_pkg::DAY_W-1:0]    day,
  output logic [cdd_pkg::DIST_W-1:0]   day_num
);

  localparam int YW = cdd_pkg::YEAR_W;
  localparam int XW = cdd_pkg::RECIP_X_W;
  localparam int PW = cdd_pkg::PROD_W;
  localparam int QW = cdd_pkg::QUOT_W;
  localparam int NW = cdd_pkg::DIST_W;
  localparam int EW = cdd_pkg::DBM_W;

  // stage 2: products
  logic [YW-1:0]                 year2;
  logic [cdd_pkg::MONTH_W-1:0]   month2;
  logic [cdd_pkg::DAY_W-1:0]     day2;
  logic [NW-1:0]                 y365;
  logic [PW-1:0]                 p100;
  logic [PW-1:0]                 p400;
  logic [PW-1:0]                 pfl;

  logic [XW-1:0] x100;
  logic [XW-1:0] x400;

  assign x100 = XW'(year) + XW'(99);
  assign x400 = XW'((XW'(year) + XW'(399)) >> 2);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      year2  <= year;
      month2 <= month;
      day2   <= day;
      y365   <= NW'(year * cdd_pkg::DAYS_PER_YEAR);
      p100   <= PW'(x100 * cdd_pkg::RECIP100);
      p400   <= PW'(x400 * cdd_pkg::RECIP100);
      pfl    <= PW'(XW'(year) * cdd_pkg::RECIP100);
    end
  end

  // stage 3: whole years and the in-year part
  logic [NW-1:0] years_days;
  logic [EW-1:0] extra;

  logic [QW-1:0]   q100;
  logic [QW-1:0]   q400;
  logic [QW-1:0]   cent;
  logic [YW-2:0]   q4;
  logic [QW+6:0]   cent_x100;
  logic            leap;
  logic            leap_add;

  assign q100      = p100[PW-1:cdd_pkg::RECIP_SHIFT];
  assign q400      = p400[PW-1:cdd_pkg::RECIP_SHIFT];
  assign cent      = pfl[PW-1:cdd_pkg::RECIP_SHIFT];
  assign q4        = (YW-1)'((XW'(year2) + XW'(3)) >> 2);
  assign cent_x100 = (QW+7)'(cent * 7'd100);
  assign leap      = (year2[1:0] == 2'b00) &&
                     ((cent_x100 != (QW+7)'(year2)) || (cent[1:0] == 2'b00));
  assign leap_add  = leap && (month2 >= 4'd3);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      years_days <= y365 + NW'(q4) - NW'(q100) + NW'(q400);
      extra      <= cdd_pkg::days_before(month2) + EW'(leap_add) + EW'(day2);
    end
  end

  // stage 4: day number
  always_ff @(posedge clk) begin
    if (en.s4) begin
      day_num <= years_days + NW'(extra);
    end
  end

endmodule
